[src/assignment_line_parser_defines.svh]
// assertion helpers for the assignment line parser
`ifndef ASSIGNMENT_LINE_PARSER_DEFINES_SVH
`define ASSIGNMENT_LINE_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// plain property check under clock and active-low reset
`define ALP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// same-cycle implication
`define ALP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ALP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ALP_ASSERT(lbl, clk, rstn, prop)
`define ALP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ALP_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[src/alp_pkg.sv]
`default_nettype none

package alp_pkg;

  // default length limits
  localparam int unsigned IdLimitDef  = 50;
  localparam int unsigned ArgLimitDef = 480;

  // characters of the grammar
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef enum logic [2:0] {
    PH_START,
    PH_IDENT,
    PH_PRE_EQ,
    PH_PRE_Q,
    PH_ARG,
    PH_PRE_SEMI,
    PH_TAIL,
    PH_COMMENT
  } alp_phase_e;

  typedef enum logic [1:0] {
    KIND_IDENT  = 2'd0,
    KIND_ARG    = 2'd1,
    KIND_STATUS = 2'd2
  } alp_kind_e;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_BAD_LEAD   = 4'd1,
    ST_ID_LONG    = 4'd2,
    ST_NO_EQ      = 4'd3,
    ST_NO_OPEN_Q  = 4'd4,
    ST_NO_CLOSE_Q = 4'd5,
    ST_ARG_LONG   = 4'd6,
    ST_NO_SEMI    = 4'd7,
    ST_TRAILING   = 4'd8
  } alp_status_e;

  // one result beat out of the step logic
  typedef struct packed {
    logic        vld;
    alp_kind_e   kind;
    logic [7:0]  data;
    alp_status_e status;
  } alp_res_t;

  function automatic logic is_word(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || (c == ChUnder);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

endpackage

`default_nettype wire

[src/alp_step.sv]
`default_nettype none

module alp_step #(
  parameter int unsigned ID_LIMIT  = alp_pkg::IdLimitDef,
  parameter int unsigned ARG_LIMIT = alp_pkg::ArgLimitDef,
  localparam int unsigned IdW  = $clog2(ID_LIMIT),
  localparam int unsigned ArgW = $clog2(ARG_LIMIT)
) (
  input  wire logic [7:0]           ch_i,
  input  wire alp_pkg::alp_phase_e  phase_i,
  input  wire logic [IdW-1:0]       ident_len_i,
  input  wire logic [ArgW-1:0]      arg_len_i,
  input  wire alp_pkg::alp_status_e err_i,
  output alp_pkg::alp_phase_e       phase_o,
  output logic [IdW-1:0]            ident_len_o,
  output logic [ArgW-1:0]           arg_len_o,
  output alp_pkg::alp_status_e      err_o,
  output alp_pkg::alp_res_t         res_o
);

  localparam logic [IdW-1:0]  IdMax  = IdW'(ID_LIMIT - 1);
  localparam logic [ArgW-1:0] ArgMax = ArgW'(ARG_LIMIT - 1);

  logic            word, blank, count_id;
  logic [IdW-1:0]  id_inc;
  logic [ArgW-1:0] arg_inc;

  assign word    = alp_pkg::is_word(ch_i);
  assign blank   = alp_pkg::is_blank(ch_i);
  assign id_inc  = ident_len_i + 1'b1;
  assign arg_inc = arg_len_i + 1'b1;

  always_comb begin
    phase_o     = phase_i;
    ident_len_o = ident_len_i;
    arg_len_o   = arg_len_i;
    err_o       = err_i;
    count_id    = 1'b0;
    res_o       = '{vld: 1'b0, kind: alp_pkg::KIND_IDENT, data: 8'h00,
                    status: alp_pkg::ST_OK};

    if (ch_i == alp_pkg::ChNul) begin
      res_o.vld  = 1'b1;
      res_o.kind = alp_pkg::KIND_STATUS;
      if (err_i != alp_pkg::ST_OK) begin
        res_o.status = err_i;
      end else begin
        unique case (phase_i)
          alp_pkg::PH_START:                       res_o.status = alp_pkg::ST_BAD_LEAD;
          alp_pkg::PH_IDENT, alp_pkg::PH_PRE_EQ:   res_o.status = alp_pkg::ST_NO_EQ;
          alp_pkg::PH_PRE_Q:                       res_o.status = alp_pkg::ST_NO_OPEN_Q;
          alp_pkg::PH_ARG:                         res_o.status = alp_pkg::ST_NO_CLOSE_Q;
          alp_pkg::PH_PRE_SEMI:                    res_o.status = alp_pkg::ST_NO_SEMI;
          default:                                 res_o.status = alp_pkg::ST_OK;
        endcase
      end
      phase_o     = alp_pkg::PH_START;
      ident_len_o = '0;
      arg_len_o   = '0;
      err_o       = alp_pkg::ST_OK;
    end else if (err_i == alp_pkg::ST_OK) begin
      unique case (phase_i)
        alp_pkg::PH_START: begin
          if (!word) begin
            err_o = alp_pkg::ST_BAD_LEAD;
          end else begin
            phase_o  = alp_pkg::PH_IDENT;
            count_id = 1'b1;
          end
        end
        alp_pkg::PH_IDENT: begin
          if (ident_len_i != '0 && !word) begin
            if (blank) phase_o = alp_pkg::PH_PRE_EQ;
            else if (ch_i == alp_pkg::ChEq) phase_o = alp_pkg::PH_PRE_Q;
            else err_o = alp_pkg::ST_NO_EQ;
          end else begin
            count_id = 1'b1;
          end
        end
        alp_pkg::PH_PRE_EQ: begin
          if (ch_i == alp_pkg::ChEq) phase_o = alp_pkg::PH_PRE_Q;
          else if (!blank) err_o = alp_pkg::ST_NO_EQ;
        end
        alp_pkg::PH_PRE_Q: begin
          if (ch_i == alp_pkg::ChQuote) phase_o = alp_pkg::PH_ARG;
          else if (!blank) err_o = alp_pkg::ST_NO_OPEN_Q;
        end
        alp_pkg::PH_ARG: begin
          if (ch_i == alp_pkg::ChQuote) begin
            phase_o = alp_pkg::PH_PRE_SEMI;
          end else begin
            arg_len_o = arg_inc;
            if (arg_inc >= ArgMax) begin
              err_o = alp_pkg::ST_ARG_LONG;
            end else begin
              res_o.vld  = 1'b1;
              res_o.kind = alp_pkg::KIND_ARG;
              res_o.data = ch_i;
            end
          end
        end
        alp_pkg::PH_PRE_SEMI: begin
          if (ch_i == alp_pkg::ChSemi) phase_o = alp_pkg::PH_TAIL;
          else if (!blank) err_o = alp_pkg::ST_NO_SEMI;
        end
        alp_pkg::PH_TAIL: begin
          if (ch_i == alp_pkg::ChHash) phase_o = alp_pkg::PH_COMMENT;
          else if (!blank) err_o = alp_pkg::ST_TRAILING;
        end
        default: ;
      endcase

      // identifier byte: count, check length, emit
      if (count_id) begin
        ident_len_o = id_inc;
        if (id_inc >= IdMax) begin
          err_o = alp_pkg::ST_ID_LONG;
        end else begin
          res_o.vld  = 1'b1;
          res_o.kind = alp_pkg::KIND_IDENT;
          res_o.data = ch_i;
        end
      end
    end
  end

endmodule

`default_nettype wire

[src/assignment_line_parser.sv]
// assignment_line_parser: streaming checker for one "name = "value";" line
//
// input channel: one line byte per beat on ch_i (in_valid_i / in_ready_o);
// a zero byte closes the line
// output channel: one result beat (out_valid_o / out_ready_i) carrying
// kind_o, byte_out_o and status_o; identifier and argument bytes come out
// as kind 0 / 1 while the line streams, the zero byte yields one status
// beat (kind 2) and returns the parser to the line-start state
// after the first error the rest of the line gives no beats up to the
// zero byte, whose status beat reports that first error
//
// path: a byte accepted goes through the input register and then the result
// register before its result beat is on the outputs
// throughput: one byte per cycle while no stall holds the input
// stall: while out_ready_i is low a full result register holds; the input
// register still drains bytes that give no result, and in_ready_o drops
// only when both registers are full and the pending byte has a result
// reset: clears both valid flags, phase, lengths and the latched error
`default_nettype none

`include "assignment_line_parser_defines.svh"

module assignment_line_parser #(
  parameter int unsigned ID_LIMIT  = alp_pkg::IdLimitDef,
  parameter int unsigned ARG_LIMIT = alp_pkg::ArgLimitDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] ch_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      byte_out_o,
  output logic [3:0]      status_o
);

  localparam int unsigned IdW  = $clog2(ID_LIMIT);
  localparam int unsigned ArgW = $clog2(ARG_LIMIT);

  // input register
  logic       s_vld_q;
  logic [7:0] s_ch_q;

  // parser state
  alp_pkg::alp_phase_e  phase_q, phase_d;
  logic [IdW-1:0]       ident_len_q, ident_len_d;
  logic [ArgW-1:0]      arg_len_q, arg_len_d;
  alp_pkg::alp_status_e err_q, err_d;

  // result register
  logic              out_vld_q;
  alp_pkg::alp_res_t res, out_q;

  logic fire;

  alp_step #(
    .ID_LIMIT (ID_LIMIT),
    .ARG_LIMIT(ARG_LIMIT)
  ) u_step (
    .ch_i       (s_ch_q),
    .phase_i    (phase_q),
    .ident_len_i(ident_len_q),
    .arg_len_i  (arg_len_q),
    .err_i      (err_q),
    .phase_o    (phase_d),
    .ident_len_o(ident_len_d),
    .arg_len_o  (arg_len_d),
    .err_o      (err_d),
    .res_o      (res)
  );

  // the held byte moves on unless it has a result and the output is blocked
  assign fire       = s_vld_q && (!res.vld || !out_vld_q || out_ready_i);
  assign in_ready_o = !s_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q     <= 1'b0;
      out_vld_q   <= 1'b0;
      phase_q     <= alp_pkg::PH_START;
      ident_len_q <= '0;
      arg_len_q   <= '0;
      err_q       <= alp_pkg::ST_OK;
    end else begin
      if (in_ready_o) begin
        s_vld_q <= in_valid_i;
      end
      if (fire) begin
        phase_q     <= phase_d;
        ident_len_q <= ident_len_d;
        arg_len_q   <= arg_len_d;
        err_q       <= err_d;
      end
      if (fire && res.vld) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s_ch_q <= ch_i;
    end
    if (fire && res.vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign kind_o      = out_q.kind;
  assign byte_out_o  = out_q.data;
  assign status_o    = out_q.status;

  // byte beats carry ok status and a nonzero byte
  `ALP_ASSERT_IMP(a_byte_beat, clk_i, rst_ni,
    out_vld_q && out_q.kind != alp_pkg::KIND_STATUS,
    out_q.status == alp_pkg::ST_OK && out_q.data != 8'h00)
  // a status beat never carries a byte
  `ALP_ASSERT_IMP(a_status_beat, clk_i, rst_ni,
    out_vld_q && out_q.kind == alp_pkg::KIND_STATUS, out_q.data == 8'h00)
  // end of line puts the parser back to line start
  `ALP_ASSERT_NXT(a_eol_reset, clk_i, rst_ni,
    fire && s_ch_q == alp_pkg::ChNul,
    phase_q == alp_pkg::PH_START && err_q == alp_pkg::ST_OK)
  // a latched error holds until end of line
  `ALP_ASSERT_NXT(a_err_hold, clk_i, rst_ni,
    fire && s_ch_q != alp_pkg::ChNul && err_q != alp_pkg::ST_OK,
    err_q == $past(err_q) && !(out_vld_q && !$past(out_vld_q)))
  // input stalls only behind a full, blocked result register
  `ALP_ASSERT_IMP(a_stall_cause, clk_i, rst_ni,
    !in_ready_o, s_vld_q && out_vld_q && !out_ready_i)

endmodule

`default_nettype wire

[sim/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdLimit  = alp_pkg::IdLimitDef;
  localparam int unsigned ArgLimit = alp_pkg::ArgLimitDef;

  // one expected result beat
  typedef struct {
    alp_pkg::alp_kind_e   kind;
    logic [7:0]           data;
    alp_pkg::alp_status_e status;
  } token_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] ch_i        = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] byte_out_o;
  logic [3:0] status_o;

  assignment_line_parser #(
    .ID_LIMIT (IdLimit),
    .ARG_LIMIT(ArgLimit)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ch_i       (ch_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o     (kind_o),
    .byte_out_o (byte_out_o),
    .status_o   (status_o)
  );

  always #10 clk_i = ~clk_i;

  // mirror of the line parser state
  alp_pkg::alp_phase_e  line_phase;
  logic [5:0]           ident_count;
  logic [8:0]           arg_count;
  alp_pkg::alp_status_e first_error;

  token_t      pending_tokens[$];
  logic [7:0]  line_text[$];
  int unsigned fail_count = 0;
  int unsigned live_count = 0;
  bit          no_idle = 1'b0;
  string       ident_set =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

  function automatic void clear_parser();
    line_phase  = alp_pkg::PH_START;
    ident_count = '0;
    arg_count   = '0;
    first_error = alp_pkg::ST_OK;
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return (c == alp_pkg::ChSpace) || (c >= alp_pkg::ChTab && c <= alp_pkg::ChCr);
  endfunction

  // advance the mirror by one line byte; returns 1 when a result beat is due
  function automatic bit parse_char(input logic [7:0] c, output token_t tok);
    alp_pkg::alp_status_e st;
    bit                   word;
    word = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || (c == alp_pkg::ChUnder);
    tok = '{alp_pkg::KIND_STATUS, 8'h00, alp_pkg::ST_OK};
    if (c == alp_pkg::ChNul) begin
      // end of line: latched error, else whatever element was still missing
      st = first_error;
      if (st == alp_pkg::ST_OK) begin
        case (line_phase)
          alp_pkg::PH_START:                     st = alp_pkg::ST_BAD_LEAD;
          alp_pkg::PH_IDENT, alp_pkg::PH_PRE_EQ: st = alp_pkg::ST_NO_EQ;
          alp_pkg::PH_PRE_Q:                     st = alp_pkg::ST_NO_OPEN_Q;
          alp_pkg::PH_ARG:                       st = alp_pkg::ST_NO_CLOSE_Q;
          alp_pkg::PH_PRE_SEMI:                  st = alp_pkg::ST_NO_SEMI;
          default:                               st = alp_pkg::ST_OK;
        endcase
      end
      tok.status = st;
      clear_parser();
      return 1'b1;
    end
    if (first_error != alp_pkg::ST_OK) return 1'b0;
    case (line_phase)
      alp_pkg::PH_START, alp_pkg::PH_IDENT: begin
        if (!word) begin
          if (line_phase == alp_pkg::PH_START) first_error = alp_pkg::ST_BAD_LEAD;
          else if (blank_char(c)) line_phase = alp_pkg::PH_PRE_EQ;
          else if (c == alp_pkg::ChEq) line_phase = alp_pkg::PH_PRE_Q;
          else first_error = alp_pkg::ST_NO_EQ;
          return 1'b0;
        end
        line_phase  = alp_pkg::PH_IDENT;
        ident_count = ident_count + 1'b1;
        if (ident_count >= IdLimit - 1) begin
          first_error = alp_pkg::ST_ID_LONG;
          return 1'b0;
        end
        tok = '{alp_pkg::KIND_IDENT, c, alp_pkg::ST_OK};
        return 1'b1;
      end
      alp_pkg::PH_PRE_EQ: begin
        if (c == alp_pkg::ChEq) line_phase = alp_pkg::PH_PRE_Q;
        else if (!blank_char(c)) first_error = alp_pkg::ST_NO_EQ;
        return 1'b0;
      end
      alp_pkg::PH_PRE_Q: begin
        if (c == alp_pkg::ChQuote) line_phase = alp_pkg::PH_ARG;
        else if (!blank_char(c)) first_error = alp_pkg::ST_NO_OPEN_Q;
        return 1'b0;
      end
      alp_pkg::PH_ARG: begin
        if (c == alp_pkg::ChQuote) begin
          line_phase = alp_pkg::PH_PRE_SEMI;
          return 1'b0;
        end
        arg_count = arg_count + 1'b1;
        if (arg_count >= ArgLimit - 1) begin
          first_error = alp_pkg::ST_ARG_LONG;
          return 1'b0;
        end
        tok = '{alp_pkg::KIND_ARG, c, alp_pkg::ST_OK};
        return 1'b1;
      end
      alp_pkg::PH_PRE_SEMI: begin
        if (c == alp_pkg::ChSemi) line_phase = alp_pkg::PH_TAIL;
        else if (!blank_char(c)) first_error = alp_pkg::ST_NO_SEMI;
        return 1'b0;
      end
      alp_pkg::PH_TAIL: begin
        if (c == alp_pkg::ChHash) line_phase = alp_pkg::PH_COMMENT;
        else if (!blank_char(c)) first_error = alp_pkg::ST_TRAILING;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // send one line byte, with random idle cycles in front of it
  task automatic feed_char(input logic [7:0] c);
    token_t tok;
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 26) begin
      in_valid_i = 1'b0;
      ch_i       = 8'($urandom);
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    ch_i       = c;
    do @(posedge clk_i); while (!in_ready_o);
    // bytes behind a latched error are dropped by the block
    if (first_error == alp_pkg::ST_OK || c == alp_pkg::ChNul) live_count++;
    if (parse_char(c, tok)) pending_tokens.push_back(tok);
  endtask

  task automatic feed_text(input string s);
    for (int i = 0; i < s.len(); i++) feed_char(s[i]);
  endtask

  task automatic feed_line(input string s);
    feed_text(s);
    feed_char(alp_pkg::ChNul);
  endtask

  function automatic void add_blanks();
    repeat ($urandom_range(2))
      line_text.push_back($urandom_range(1) ? alp_pkg::ChSpace
                          : 8'($urandom_range(alp_pkg::ChCr, alp_pkg::ChTab)));
  endfunction

  // one random line: mostly well formed, some broken, some plain noise
  task automatic random_line();
    int unsigned pick;
    int unsigned len;
    int unsigned pos;
    logic [7:0]  c;
    line_text.delete();
    pick = $urandom_range(99);
    if (pick < 15) begin
      len = $urandom_range(8);
      repeat (len) begin
        case ($urandom_range(7))
          0:       c = alp_pkg::ChEq;
          1:       c = alp_pkg::ChQuote;
          2:       c = alp_pkg::ChSemi;
          3:       c = alp_pkg::ChHash;
          4:       c = alp_pkg::ChSpace;
          5:       c = alp_pkg::ChUnder;
          default: c = 8'($urandom_range(255, 1));
        endcase
        line_text.push_back(c);
      end
    end else begin
      // now and then an identifier near or past its length limit
      len = ($urandom_range(19) == 0) ? $urandom_range(IdLimit, IdLimit - 6)
                                      : $urandom_range(8, 1);
      repeat (len) line_text.push_back(ident_set[$urandom_range(ident_set.len() - 1)]);
      add_blanks();
      line_text.push_back(alp_pkg::ChEq);
      add_blanks();
      line_text.push_back(alp_pkg::ChQuote);
      len = $urandom_range(12);
      repeat (len) begin
        do c = 8'($urandom_range(255, 1)); while (c == alp_pkg::ChQuote);
        line_text.push_back(c);
      end
      line_text.push_back(alp_pkg::ChQuote);
      add_blanks();
      line_text.push_back(alp_pkg::ChSemi);
      add_blanks();
      if ($urandom_range(1)) begin
        line_text.push_back(alp_pkg::ChHash);
        repeat ($urandom_range(5)) line_text.push_back(8'($urandom_range(255, 1)));
      end
      // break one line in four: a stray byte or an early end
      if (pick >= 75) begin
        pos = $urandom_range(line_text.size() - 1);
        if ($urandom_range(1)) line_text[pos] = 8'($urandom);
        else while (line_text.size() > pos) void'(line_text.pop_back());
      end
    end
    foreach (line_text[i]) feed_char(line_text[i]);
    feed_char(alp_pkg::ChNul);
  endtask

  // short lines covering each status but the two length errors, and the byte extremes
  task automatic test_directed();
    feed_line("a=\"\";");
    feed_text("Zz_09 \t= \"");
    feed_char(8'hFF);
    feed_char(8'h01);
    feed_char(8'h80);
    feed_line("#;= ;\" ;  # x\"q");
    feed_char(alp_pkg::ChNul);
    feed_line("=x\"");
    feed_line("id_");
    feed_text("id");
    feed_char(alp_pkg::ChTab);
    feed_char(8'h0B);
    feed_char(8'h0C);
    feed_char(alp_pkg::ChNul);
    feed_line("id x=\"v\";");
    feed_line("id-");
    feed_line("id =");
    feed_line("id= v");
    feed_line("id=\"abc");
    feed_line("id=\"abc\"");
    feed_line("id=\"a\" ,");
    feed_line("id=\"a\";x");
    feed_text("id=\"a\";");
    feed_char(alp_pkg::ChCr);
    feed_char(8'h0A);
    feed_char(alp_pkg::ChNul);
    feed_line("id=\"a\";#\"#");
  endtask

  // identifier and value that run up to the length limits, and an identifier past it
  task automatic test_length_limits();
    int unsigned id_sizes[2]  = '{IdLimit - 1, IdLimit + 2};
    int unsigned arg_sizes[1] = '{ArgLimit - 1};
    logic [7:0]  c;
    foreach (id_sizes[k]) begin
      for (int i = 0; i < id_sizes[k]; i++) feed_char(ident_set[i % ident_set.len()]);
      feed_line("=\"v\";");
    end
    foreach (arg_sizes[k]) begin
      feed_text("v=\"");
      for (int i = 0; i < arg_sizes[k]; i++) begin
        c = 8'(i % 255 + 1);
        feed_char((c == alp_pkg::ChQuote) ? 8'hFE : c);
      end
      feed_line("\";");
    end
  endtask

  task automatic test_random_lines(input int unsigned n);
    int unsigned stop_at;
    stop_at = live_count + n;
    while (live_count < stop_at) random_line();
  endtask

  // full rate on both sides
  task automatic test_back_to_back();
    int unsigned stop_at;
    no_idle = 1'b1;
    stop_at = live_count + 80;
    while (live_count < stop_at) random_line();
    no_idle = 1'b0;
  endtask

  // receiver stalls at random
  always @(negedge clk_i) begin
    out_ready_i = no_idle || ($urandom_range(99) >= 26);
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : check_beat
    token_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_tokens.size() == 0) begin
        $error("unexpected result beat: kind %0d byte %h status %0d",
               kind_o, byte_out_o, status_o);
        fail_count++;
      end else begin
        want = pending_tokens.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          fail_count++;
        end
        if (byte_out_o !== want.data) begin
          $error("byte_out: expected %h, got %h", want.data, byte_out_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    clear_parser();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_length_limits();
    test_random_lines(80);
    test_back_to_back();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    for (int n = 0; n < 5000 && pending_tokens.size() != 0; n++) @(posedge clk_i);
    if (pending_tokens.size() != 0) begin
      $error("%0d result beats never arrived", pending_tokens.size());
      fail_count++;
    end
    // catch stray beats after the last expected one
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("assignment_line_parser verification clean");
    end else begin
      $display("assignment_line_parser verification failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #20_000_000;
    $display("assignment_line_parser verification failed");
    $finish;
  end

endmodule

`default_nettype wire
